@@ rtl/pptt_pkg.sv @@
// shared types and constants for the peer position table with timeout
// no dependencies; used by pptt_slots and peer_position_table_with_timeout
package pptt_pkg;

  // table geometry
  localparam int unsigned TABLE_SLOTS = 16;
  localparam int unsigned SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned CMP_W       = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;

  // timeout register reset value
  localparam logic [15:0] TIMEOUT_RESET = 16'd400;

  // operation codes carried in tuser
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // one table slot
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] stamp;
  } slot_entry_t;

  // write request to the slot table
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       entry;
  } slot_wr_t;

  // input tdata layout, last member in the lowest bits
  typedef struct packed {
    logic [3:0]       pad;
    logic [31:0]      pos_z;
    logic [31:0]      pos_y;
    logic [31:0]      pos_x;
    logic [IDX_W-1:0] slot_index;
    logic [7:0]       peer_id;
  } in_item_t;

  // output tdata layout, last member in the lowest bits
  typedef struct packed {
    logic               pad;
    logic [COUNT_W-1:0] active_count;
    logic [31:0]        out_stamp;
    logic [31:0]        out_z;
    logic [31:0]        out_y;
    logic [31:0]        out_x;
    logic [7:0]         entry_id;
    logic               active;
    logic               success;
  } out_item_t;

endpackage

@@ rtl/pptt_slots.sv @@
// slot table storage: ids, positions and stamps, cleared by reset
// depends on pptt_pkg
module pptt_slots (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pptt_pkg::slot_wr_t          wr_i,
  input  logic [pptt_pkg::SLOT_W-1:0] rd_addr_i,
  output pptt_pkg::slot_entry_t       rd_entry_o
);
  import pptt_pkg::*;

  slot_entry_t slots_q [TABLE_SLOTS];

  // one write port, reset clears every slot to free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TABLE_SLOTS; s++) begin
        slots_q[s] <= '0;
      end
    end else if (wr_i.we) begin
      slots_q[wr_i.addr] <= wr_i.entry;
    end
  end

  // single read port at the scan pointer
  assign rd_entry_o = slots_q[rd_addr_i];

endmodule

@@ rtl/peer_position_table_with_timeout.sv @@
// top level of the peer position table with timeout: sequencer and shared age compare
// depends on pptt_pkg and pptt_slots
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser operation, tdata fields
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata result fields
//  cfg       in         cfg_we_i                       cfg_wdata_i timeout_ticks
//
// each transaction is accepted, then scans every slot in turn through the single age
// subtract-and-compare unit, then loads the output register once that register is free.
// a tick bumps the counter when it is accepted. reset clears the table and
// the counter at once. input stays not ready until the result is in the output register,
// which holds it while m_axis_tready is low.
module peer_position_table_with_timeout (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // peer_id[7:0], slot_index[11:8], pos_x[43:12], pos_y[75:44], pos_z[107:76], zero pad
  input  logic [111:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // success[0], active[1], entry_id[9:2], out_x[41:10], out_y[73:42], out_z[105:74],
  // out_stamp[137:106], active_count[142:138], zero pad
  output logic [143:0] m_axis_tdata
);
  import pptt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [1:0]         state_q, state_d;
  logic [SLOT_W-1:0]  ptr_q, ptr_d;
  logic [31:0]        now_q, now_d;
  logic [15:0]        timeout_q;
  logic [1:0]         op_q;
  in_item_t           item_q;
  in_item_t           item_in;
  logic               found_q, found_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  out_item_t          res_q, res_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q;

  slot_wr_t    wr;
  slot_entry_t rd_entry;
  slot_entry_t new_entry;
  logic [31:0] age;
  logic        young;
  logic        match;
  logic        hit;
  logic        add;
  logic        accept;
  logic        out_free;

  assign item_in       = in_item_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // slot storage
  pptt_slots u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .rd_addr_i  (ptr_q),
    .rd_entry_o (rd_entry)
  );

  // shared age unit
  assign age   = now_q - rd_entry.stamp;
  assign young = age < {16'd0, timeout_q};

  // entry written by a store
  always_comb begin
    new_entry.id    = item_q.peer_id;
    new_entry.x     = item_q.pos_x;
    new_entry.y     = item_q.pos_y;
    new_entry.z     = item_q.pos_z;
    new_entry.stamp = now_q;
  end

  // slot match for the current operation
  always_comb begin
    case (op_q)
      OP_STORE:  match = (rd_entry.id == 8'd0) || (rd_entry.id == item_q.peer_id);
      OP_LOOKUP: match = (rd_entry.id == item_q.peer_id);
      OP_READ:   match = (CMP_W'(item_q.slot_index) == CMP_W'(ptr_q));
      default:   match = 1'b0;
    endcase
  end

  assign hit = (state_q == ST_SCAN) && match && !found_q;

  // store write port
  always_comb begin
    wr.we    = hit && (op_q == OP_STORE);
    wr.addr  = ptr_q;
    wr.entry = new_entry;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    now_d   = now_q;
    found_d = found_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    add     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          ptr_d   = '0;
          found_d = 1'b0;
          cnt_d   = '0;
          res_d   = '0;
          if (s_axis_tuser == OP_TICK) begin
            now_d = now_q + 32'd1;
          end
        end
      end
      ST_SCAN: begin
        if (wr.we) begin
          // the freshly stored slot has age zero
          add                = (item_q.peer_id != 8'd0) && (timeout_q != 16'd0);
          res_d.success      = 1'b1;
          res_d.active       = add;
          res_d.entry_id     = new_entry.id;
          res_d.out_x        = new_entry.x;
          res_d.out_y        = new_entry.y;
          res_d.out_z        = new_entry.z;
          res_d.out_stamp    = new_entry.stamp;
        end else begin
          add = (rd_entry.id != 8'd0) && young;
          if (hit) begin
            res_d.success   = 1'b1;
            res_d.active    = (op_q == OP_LOOKUP) ? young : add;
            res_d.entry_id  = rd_entry.id;
            res_d.out_x     = rd_entry.x;
            res_d.out_y     = rd_entry.y;
            res_d.out_z     = rd_entry.z;
            res_d.out_stamp = rd_entry.stamp;
          end
        end
        found_d = found_q || hit;
        if (add && (cnt_q != COUNT_MAX)) begin
          cnt_d = cnt_q + COUNT_W'(1);
        end
        if (ptr_q == LAST_SLOT) begin
          state_d = ST_OUT;
        end else begin
          ptr_d = ptr_q + SLOT_W'(1);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result word with the final active count
  always_comb begin
    out_d              = res_q;
    out_d.active_count = cnt_q;
    out_d.pad          = 1'b0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      now_q       <= '0;
      found_q     <= 1'b0;
      cnt_q       <= '0;
      timeout_q   <= TIMEOUT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      now_q   <= now_d;
      found_q <= found_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      item_q <= item_in;
    end
    res_q <= res_d;
    if (state_q == ST_OUT && out_free) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // at most one slot is taken per transaction
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |=> found_q)
    else $error("second hit in one scan");

  // a tick never selects a slot
  a_tick_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && op_q == OP_TICK) |-> !hit && !found_q)
    else $error("tick selected a slot");

  // an accepted transaction starts a scan at slot zero
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) && (ptr_q == '0))
    else $error("scan did not start at slot zero");

  // the scan ends after the last slot
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && ptr_q == LAST_SLOT) |=> state_q == ST_OUT)
    else $error("scan did not end at last slot");

  // the output register is loaded only when free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !m_axis_tready) |=> state_q == ST_OUT)
    else $error("result loaded over a pending one");

endmodule

@@ test/tb_peer_position_table_with_timeout.sv @@
// testbench for peer_position_table_with_timeout: stream driver, result monitor and a
// cycle-free predictor of the slot table, tick counter and timeout register
// depends on pptt_pkg and the rtl top level
module tb_peer_position_table_with_timeout;
  timeunit 1ns;
  timeprecision 1ps;

  import pptt_pkg::*;

  // one input transaction before packing
  typedef struct {
    logic [1:0]  op;
    logic [7:0]  peer_id;
    logic [3:0]  slot_index;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } table_op_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [15:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = OP_TICK;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;

  // operations waiting to be sent, and the results they are predicted to give
  table_op_t queued_ops[$];
  out_item_t predicted_reports[$];
  table_op_t held_op;
  logic [7:0] stored_ids[$];
  bit         steady_run = 1'b0;
  int unsigned fault_count = 0;

  // predictor copy of the table, the tick counter and the timeout register
  logic [7:0]  tbl_id[TABLE_SLOTS];
  logic [31:0] tbl_x[TABLE_SLOTS];
  logic [31:0] tbl_y[TABLE_SLOTS];
  logic [31:0] tbl_z[TABLE_SLOTS];
  logic [31:0] tbl_stamp[TABLE_SLOTS];
  logic [31:0] tick_now;
  logic [15:0] timeout_now;

  peer_position_table_with_timeout DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // age check uses modulo 2^32 difference
  function automatic logic slot_is_young(int unsigned s);
    logic [31:0] age;
    age = tick_now - tbl_stamp[s];
    return age < {16'd0, timeout_now};
  endfunction

  function automatic logic slot_is_live(int unsigned s);
    return (tbl_id[s] != 8'd0) && slot_is_young(s);
  endfunction

  function automatic out_item_t show_slot(int unsigned s, logic act);
    out_item_t res;
    res = '0;
    res.success   = 1'b1;
    res.active    = act;
    res.entry_id  = tbl_id[s];
    res.out_x     = tbl_x[s];
    res.out_y     = tbl_y[s];
    res.out_z     = tbl_z[s];
    res.out_stamp = tbl_stamp[s];
    return res;
  endfunction

  // apply one operation to the predicted table and return its result
  function automatic out_item_t predict_table_op(table_op_t t);
    out_item_t   res;
    logic        hit;
    int unsigned live;
    res  = '0;
    hit  = 1'b0;
    live = 0;
    case (t.op)
      OP_TICK: begin
        tick_now = tick_now + 32'd1;
      end
      OP_STORE: begin
        for (int unsigned s = 0; s < TABLE_SLOTS; s++) begin
          if (!hit && (tbl_id[s] == 8'd0 || tbl_id[s] == t.peer_id)) begin
            hit          = 1'b1;
            tbl_id[s]    = t.peer_id;
            tbl_x[s]     = t.pos_x;
            tbl_y[s]     = t.pos_y;
            tbl_z[s]     = t.pos_z;
            tbl_stamp[s] = tick_now;
            res          = show_slot(s, slot_is_live(s));
          end
        end
      end
      OP_LOOKUP: begin
        for (int unsigned s = 0; s < TABLE_SLOTS; s++) begin
          if (!hit && tbl_id[s] == t.peer_id) begin
            hit = 1'b1;
            res = show_slot(s, slot_is_young(s));
          end
        end
      end
      default: begin
        if (t.slot_index < TABLE_SLOTS)
          res = show_slot(32'(t.slot_index), slot_is_live(32'(t.slot_index)));
      end
    endcase
    for (int unsigned s = 0; s < TABLE_SLOTS; s++) begin
      if (slot_is_live(s)) live++;
    end
    res.active_count = (live > 31) ? 5'd31 : live[4:0];
    return res;
  endfunction

  // small pool keeps the table from filling, the wide draw fills it
  function automatic logic [7:0] draw_peer_id(bit wide_ids);
    int unsigned v;
    if (wide_ids) return 8'($urandom_range(0, 255));
    v = $urandom_range(0, 12);
    if (v == 11) return 8'hFF;
    if (v == 12) return 8'h80;
    return 8'(v);
  endfunction

  function automatic table_op_t random_op(bit wide_ids);
    table_op_t   t;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 36) t.op = OP_TICK;
    else if (pick < 66) t.op = OP_STORE;
    else if (pick < 86) t.op = OP_LOOKUP;
    else t.op = OP_READ;
    t.peer_id = draw_peer_id(wide_ids);
    // lookups mostly aim at ids that were stored
    if (t.op == OP_LOOKUP && stored_ids.size() != 0 && $urandom_range(0, 3) != 0)
      t.peer_id = stored_ids[$urandom_range(0, stored_ids.size() - 1)];
    if (t.op == OP_STORE) stored_ids.push_back(t.peer_id);
    t.slot_index = 4'($urandom_range(0, 15));
    t.pos_x      = $urandom();
    t.pos_y      = $urandom();
    t.pos_z      = $urandom();
    return t;
  endfunction

  task automatic queue_op(logic [1:0] op, logic [7:0] id, logic [3:0] idx,
                          logic [31:0] x, logic [31:0] y, logic [31:0] z);
    table_op_t t;
    t.op         = op;
    t.peer_id    = id;
    t.slot_index = idx;
    t.pos_x      = x;
    t.pos_y      = y;
    t.pos_z      = z;
    queued_ops.push_back(t);
  endtask

  // sample on the falling edge so pushes at the rising edge are settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (queued_ops.size() != 0 || s_axis_tvalid || predicted_reports.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_now = value;
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10) $display("mismatch %s: expected %0h actual %0h", what, want, got);
    end
  endtask

  // input driver: valid holds until the transaction is taken
  always @(posedge clk_i) begin
    table_op_t nxt;
    in_item_t  word;
    logic      drive_valid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      drive_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_reports.push_back(predict_table_op(held_op));
        drive_valid = 1'b0;
      end
      if (!drive_valid && queued_ops.size() != 0 &&
          (steady_run || $urandom_range(0, 99) >= 37)) begin
        nxt             = queued_ops.pop_front();
        word.pad        = '0;
        word.pos_z      = nxt.pos_z;
        word.pos_y      = nxt.pos_y;
        word.pos_x      = nxt.pos_x;
        word.slot_index = nxt.slot_index;
        word.peer_id    = nxt.peer_id;
        held_op        <= nxt;
        s_axis_tdata   <= word;
        s_axis_tuser   <= nxt.op;
        drive_valid     = 1'b1;
      end
      s_axis_tvalid <= drive_valid;
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (predicted_reports.size() == 0) begin
          check_field("result with nothing pending", 32'd0, 32'd1);
        end else begin
          want = predicted_reports.pop_front();
          check_field("success", 32'(want.success), 32'(got.success));
          check_field("active", 32'(want.active), 32'(got.active));
          check_field("entry_id", 32'(want.entry_id), 32'(got.entry_id));
          check_field("out_x", want.out_x, got.out_x);
          check_field("out_y", want.out_y, got.out_y);
          check_field("out_z", want.out_z, got.out_z);
          check_field("out_stamp", want.out_stamp, got.out_stamp);
          check_field("active_count", 32'(want.active_count), 32'(got.active_count));
        end
      end
      m_axis_tready <= steady_run || ($urandom_range(0, 99) >= 37);
    end
  end

  // hard limit on run length
  initial begin
    #5_000_000;
    $display("peer_position_table_with_timeout verification failed");
    $finish;
  end

  // stimulus sequence
  initial begin
    logic [15:0] phase_timeout[6];
    bit          phase_wide[6];
    tick_now    = '0;
    timeout_now = TIMEOUT_RESET;
    for (int unsigned s = 0; s < TABLE_SLOTS; s++) begin
      tbl_id[s]    = '0;
      tbl_x[s]     = '0;
      tbl_y[s]     = '0;
      tbl_z[s]     = '0;
      tbl_stamp[s] = '0;
    end
    phase_timeout = '{16'd65535, 16'd1, 16'd12, 16'($urandom_range(1, 65535)), 16'd40, 16'd3};
    phase_wide    = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, free-slot lookup, id and position extremes, id zero store
    queue_op(OP_READ, 8'h00, 4'd0, '0, '0, '0);
    queue_op(OP_READ, 8'hFF, 4'd15, '1, '1, '1);
    queue_op(OP_LOOKUP, 8'h00, 4'd0, '0, '0, '0);
    queue_op(OP_LOOKUP, 8'hFF, 4'd0, '0, '0, '0);
    queue_op(OP_STORE, 8'hFF, 4'd15, '1, '1, '1);
    queue_op(OP_STORE, 8'h01, 4'd0, '0, '0, '0);
    queue_op(OP_STORE, 8'h00, 4'd5, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h8000_0001);
    queue_op(OP_LOOKUP, 8'h00, 4'd0, '0, '0, '0);
    queue_op(OP_LOOKUP, 8'hFF, 4'd0, '0, '0, '0);
    queue_op(OP_LOOKUP, 8'h01, 4'd0, '0, '0, '0);
    queue_op(OP_TICK, 8'h00, 4'd0, '0, '0, '0);
    queue_op(OP_STORE, 8'hFF, 4'd10, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_F0F0);
    queue_op(OP_READ, 8'h00, 4'd0, '0, '0, '0);
    queue_op(OP_READ, 8'h00, 4'd1, '0, '0, '0);
    queue_op(OP_READ, 8'h00, 4'd2, '0, '0, '0);
    queue_op(OP_READ, 8'h00, 4'd15, '0, '0, '0);
    queue_op(OP_LOOKUP, 8'h7F, 4'd0, '0, '0, '0);
    queue_op(OP_TICK, 8'hFF, 4'd15, '1, '1, '1);
    wait_drained();

    // random phases, each under its own timeout; the sender waits for all results between
    for (int p = 0; p < 6; p++) begin
      write_timeout(phase_timeout[p]);
      steady_run = (p == 2);
      repeat (130) queued_ops.push_back(random_op(phase_wide[p]));
      wait_drained();
    end
    steady_run = 1'b0;

    repeat (40) @(posedge clk_i);
    if (fault_count == 0 && predicted_reports.size() == 0) begin
      $display("peer_position_table_with_timeout verification clean");
    end else begin
      $display("peer_position_table_with_timeout verification failed");
    end
    $finish;
  end

endmodule
